[sv/kth_smallest_select_assert.svh]
// assertion macros for the rank selection block
`ifndef KTH_SMALLEST_SELECT_ASSERT_SVH
`define KTH_SMALLEST_SELECT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define KSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define KSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define KSS_ASSERT_NOW(label, clk, rst, ante, cons)
`define KSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/kss_pkg.sv]
// shared constants and types for the rank selection block
package kss_pkg;

  localparam int MAX_ELEMENTS  = 1024;
  localparam int ELEMENT_WIDTH = 32;
  localparam int IDX_W         = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W         = $clog2(MAX_ELEMENTS + 1);
  localparam int RANK_W        = 10;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int CMP_W         = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [RANK_W-1:0]        rank_t;
  typedef logic [STATUS_W-1:0]      status_t;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_BAD_RANK = 2'd1;
  localparam status_t STATUS_OVERFLOW = 2'd2;

endpackage

[sv/kth_smallest_select.sv]
// rank selection: element store, median-of-three quickselect sequencer, result register
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | element_value, wanted_rank, last_element
//  out     | out_valid/out_ready| selected_value, status
//
// loading accepts one item per cycle; in_ready is high only while loading
// a last item starts selection: per window a setup picks the median-of-three pivot,
// the scan takes one element per cycle unless a swap holds it, then the pivot is placed
// the store (one write port, one registered read port) sets these steps
// an error result goes from S_CHECK straight to S_EMIT, with no store traffic
// a result waits in its register while out_ready is low; reset empties the store count
`include "kth_smallest_select_assert.svh"

module kth_smallest_select (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                element_value,
  input  logic [kss_pkg::RANK_W-1:0] wanted_rank,
  input  logic                       last_element,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                selected_value,
  output logic [1:0]                 status
);

  typedef enum logic [4:0] {
    S_LOAD, S_CHECK, S_WIN, S_M1, S_M2, S_SWAP2, S_M3, S_PWR,
    S_SCAN, S_SWAP_A, S_SWAP_B, S_FINAL, S_FIN_A, S_FIN_B, S_NARROW, S_RES,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {PICK_LO, PICK_HI, PICK_MID} pick_t;

  state_t           state;
  kss_pkg::cnt_t    element_count;
  logic             overflow_seen;
  kss_pkg::idx_t    window_low;
  kss_pkg::idx_t    window_high;
  kss_pkg::idx_t    scan_index;
  kss_pkg::idx_t    store_position;
  kss_pkg::elem_t   pivot_value;
  kss_pkg::rank_t   target_rank;
  kss_pkg::elem_t   val_lo;
  kss_pkg::elem_t   val_hi;
  kss_pkg::elem_t   val_scan;
  kss_pkg::elem_t   res_value;
  kss_pkg::status_t res_status;

  kss_pkg::elem_t   mem [kss_pkg::MAX_ELEMENTS];
  kss_pkg::elem_t   rdata;
  logic             mem_we;
  kss_pkg::idx_t    mem_waddr;
  kss_pkg::elem_t   mem_wdata;
  kss_pkg::idx_t    mem_raddr;

  logic             in_take;
  logic             store_full;
  kss_pkg::idx_t    span;
  kss_pkg::idx_t    mid;
  kss_pkg::idx_t    target_idx;
  kss_pkg::idx_t    scan_inc;
  logic             scan_end;
  logic             two_elems;
  logic             scan_less;
  logic             hi_less;
  pick_t            pick;
  logic             out_free;

  assign in_ready   = (state == S_LOAD);
  assign in_take    = in_valid && in_ready;
  assign store_full = (element_count == kss_pkg::cnt_t'(kss_pkg::MAX_ELEMENTS));
  assign span       = window_high - window_low;
  assign mid        = window_low + (span >> 1);
  assign two_elems  = (span == kss_pkg::idx_t'(1));
  assign target_idx = kss_pkg::idx_t'(target_rank);
  assign scan_inc   = scan_index + kss_pkg::idx_t'(1);
  assign scan_end   = (scan_inc == window_high);
  assign scan_less  = (rdata < pivot_value);
  assign hi_less    = (rdata < val_lo);
  assign out_free   = !out_valid || out_ready;

  // median of three over low, high and middle entries
  always_comb begin
    if (val_lo < val_hi) begin
      if (rdata < val_lo) pick = PICK_LO;
      else if (rdata > val_hi) pick = PICK_HI;
      else pick = PICK_MID;
    end else begin
      if (rdata > val_lo) pick = PICK_LO;
      else if (rdata < val_hi) pick = PICK_HI;
      else pick = PICK_MID;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = window_high;
    mem_wdata = pivot_value;
    mem_raddr = window_low;
    unique case (state)
      S_LOAD: begin
        mem_we    = in_take && !store_full;
        mem_waddr = element_count[kss_pkg::IDX_W-1:0];
        mem_wdata = kss_pkg::elem_t'(element_value);
      end
      S_M1: mem_raddr = window_high;
      S_M2: begin
        mem_raddr = mid;
        mem_we    = two_elems && hi_less;
        mem_waddr = window_high;
        mem_wdata = val_lo;
      end
      S_SWAP2: begin
        mem_we    = 1'b1;
        mem_waddr = window_low;
        mem_wdata = val_hi;
      end
      S_M3: begin
        mem_we    = (pick != PICK_HI);
        mem_waddr = (pick == PICK_LO) ? window_low : mid;
        mem_wdata = val_hi;
      end
      S_PWR: begin
        mem_we    = 1'b1;
        mem_waddr = window_high;
        mem_wdata = pivot_value;
        mem_raddr = window_low;
      end
      S_SCAN: begin
        mem_raddr = (scan_less && scan_index != store_position) ? store_position : scan_inc;
      end
      S_SWAP_A: begin
        mem_we    = 1'b1;
        mem_waddr = scan_index;
        mem_wdata = rdata;
      end
      S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = store_position;
        mem_wdata = val_scan;
        mem_raddr = scan_inc;
      end
      S_FINAL: mem_raddr = store_position;
      S_FIN_A: begin
        mem_we    = 1'b1;
        mem_waddr = window_high;
        mem_wdata = rdata;
      end
      S_FIN_B: begin
        mem_we    = 1'b1;
        mem_waddr = store_position;
        mem_wdata = pivot_value;
      end
      S_NARROW: mem_raddr = target_idx;
      S_CHECK, S_WIN, S_RES, S_EMIT: mem_raddr = window_low;
      default: mem_raddr = window_low;
    endcase
  end

  // element store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_LOAD;
      element_count  <= '0;
      overflow_seen  <= 1'b0;
      window_low     <= '0;
      window_high    <= '0;
      scan_index     <= '0;
      store_position <= '0;
      pivot_value    <= '0;
      target_rank    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_take) begin
            if (store_full) overflow_seen <= 1'b1;
            else element_count <= element_count + kss_pkg::cnt_t'(1);
            if (last_element) begin
              target_rank <= wanted_rank;
              state       <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          window_low  <= '0;
          window_high <= kss_pkg::idx_t'(element_count - kss_pkg::cnt_t'(1));
          res_value   <= '0;
          if (overflow_seen) begin
            res_status <= kss_pkg::STATUS_OVERFLOW;
            state      <= S_EMIT;
          end else if (kss_pkg::CMP_W'(target_rank) >= kss_pkg::CMP_W'(element_count)) begin
            res_status <= kss_pkg::STATUS_BAD_RANK;
            state      <= S_EMIT;
          end else begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          if (span == '0) begin
            store_position <= window_low;
            state          <= S_NARROW;
          end else begin
            state <= S_M1;
          end
        end
        S_M1: begin
          val_lo <= rdata;
          state  <= S_M2;
        end
        S_M2: begin
          val_hi <= rdata;
          if (two_elems) begin
            store_position <= window_low;
            state          <= hi_less ? S_SWAP2 : S_NARROW;
          end else begin
            state <= S_M3;
          end
        end
        S_SWAP2: state <= S_NARROW;
        S_M3: begin
          unique case (pick)
            PICK_LO:  pivot_value <= val_lo;
            PICK_HI:  pivot_value <= val_hi;
            PICK_MID: pivot_value <= rdata;
            default:  pivot_value <= val_hi;
          endcase
          state <= S_PWR;
        end
        S_PWR: begin
          scan_index     <= window_low;
          store_position <= window_low;
          state          <= S_SCAN;
        end
        S_SCAN: begin
          val_scan <= rdata;
          if (scan_less && scan_index != store_position) begin
            state <= S_SWAP_A;
          end else begin
            if (scan_less) store_position <= store_position + kss_pkg::idx_t'(1);
            scan_index <= scan_inc;
            state      <= scan_end ? S_FINAL : S_SCAN;
          end
        end
        S_SWAP_A: state <= S_SWAP_B;
        S_SWAP_B: begin
          store_position <= store_position + kss_pkg::idx_t'(1);
          scan_index     <= scan_inc;
          state          <= scan_end ? S_FINAL : S_SCAN;
        end
        S_FINAL: state <= (store_position == window_high) ? S_NARROW : S_FIN_A;
        S_FIN_A: state <= S_FIN_B;
        S_FIN_B: state <= S_NARROW;
        S_NARROW: begin
          if (store_position == target_idx) begin
            state <= S_RES;
          end else if (store_position < target_idx) begin
            window_low <= store_position + kss_pkg::idx_t'(1);
            state      <= S_WIN;
          end else begin
            window_high <= store_position - kss_pkg::idx_t'(1);
            state       <= S_WIN;
          end
        end
        S_RES: begin
          res_value  <= rdata;
          res_status <= kss_pkg::STATUS_OK;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            selected_value <= kss_pkg::VALUE_W'(res_value);
            status         <= res_status;
            element_count  <= '0;
            overflow_seen  <= 1'b0;
            state          <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `KSS_ASSERT_NOW(a_err_zero, clk, rst, out_valid && status != kss_pkg::STATUS_OK, selected_value == '0)
  `KSS_ASSERT_NOW(a_target_in_window, clk, rst, state == S_WIN, window_low <= target_idx && target_idx <= window_high)
  `KSS_ASSERT_NOW(a_scan_bounds, clk, rst, state == S_SCAN, scan_index < window_high && store_position <= scan_index)
  `KSS_ASSERT_NEXT(a_busy_after_last, clk, rst, in_valid && in_ready && last_element, !in_ready)

endmodule

[dv/kth_smallest_select_tb.sv]
// testbench for kth_smallest_select: directed table and random data sets, checked per result
`timescale 1ns / 100ps

module kth_smallest_select_tb;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SMALL_SET_ITEMS = 70;
  localparam int unsigned TAIL_CYCLES = 60;

  typedef struct packed {
    logic [31:0]      value;
    kss_pkg::status_t status;
  } pick_t;

  typedef struct packed {
    logic [31:0]      value;
    kss_pkg::rank_t   rank;
    logic             last;
    logic             typed;
    logic [31:0]      want_value;
    kss_pkg::status_t want_status;
  } stim_row_t;

  typedef enum int unsigned {
    SHAPE_RANDOM,
    SHAPE_NARROW,
    SHAPE_EQUAL,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EXTREME
  } value_shape_e;

  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{32'hFFFF_FFFF, 10'd0,    1'b1, 1'b1, 32'hFFFF_FFFF, kss_pkg::STATUS_OK},
    '{32'h0000_0000, 10'd1,    1'b1, 1'b1, 32'h0,         kss_pkg::STATUS_BAD_RANK},
    '{32'h0000_0005, 10'd1023, 1'b1, 1'b1, 32'h0,         kss_pkg::STATUS_BAD_RANK},
    '{32'h0000_0007, 10'd1023, 1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0003, 10'd2,    1'b1, 1'b1, 32'h0,         kss_pkg::STATUS_BAD_RANK},
    '{32'h0000_0007, 10'd512,  1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0003, 10'd0,    1'b1, 1'b1, 32'h3,         kss_pkg::STATUS_OK},
    '{32'hFFFF_FFFF, 10'd341,  1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0000, 10'd682,  1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h8000_0000, 10'd2,    1'b1, 1'b1, 32'hFFFF_FFFF, kss_pkg::STATUS_OK},
    '{32'h0000_0009, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0001, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0009, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0001, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0005, 10'd2,    1'b1, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_002A, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_002A, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_002A, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_002A, 10'd3,    1'b1, 1'b1, 32'h2A,        kss_pkg::STATUS_OK},
    '{32'h0000_0032, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0028, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_001E, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_0014, 10'd0,    1'b0, 1'b0, 32'h0,         kss_pkg::STATUS_OK},
    '{32'h0000_000A, 10'd1,    1'b1, 1'b0, 32'h0,         kss_pkg::STATUS_OK}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [31:0]    element_value = '0;
  kss_pkg::rank_t wanted_rank = '0;
  logic           last_element = 1'b0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [31:0]    selected_value;
  logic [1:0]     status;

  logic [31:0] shadow_elems [kss_pkg::MAX_ELEMENTS];
  int unsigned shadow_count = 0;
  bit          shadow_overflow = 1'b0;
  pick_t       expected_picks [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  kth_smallest_select i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .element_value  (element_value),
    .wanted_rank    (wanted_rank),
    .last_element   (last_element),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .selected_value (selected_value),
    .status         (status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("kth_smallest_select_tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_picks
    pick_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: selected_value %08h status %0d", selected_value, status);
        failures++;
      end else begin
        want = expected_picks.pop_front();
        if (selected_value !== want.value) begin
          $error("selected_value: expected %08h, got %08h", want.value, selected_value);
          failures++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          failures++;
        end
      end
    end
  end

  function automatic void swap_elems(int unsigned a, int unsigned b);
    logic [31:0] t;
    t = shadow_elems[a];
    shadow_elems[a] = shadow_elems[b];
    shadow_elems[b] = t;
  endfunction

  // lomuto partition of [lo, hi] around the median of lo, middle and hi; windows of one or two entries are just ordered
  function automatic int unsigned partition_window(int unsigned lo, int unsigned hi);
    int unsigned mid, piv, pos, s;
    logic [31:0] a, b, c, pv;
    if (hi < lo + 2) begin
      if (hi != lo && shadow_elems[hi] < shadow_elems[lo])
        swap_elems(hi, lo);
      return lo;
    end
    mid = lo + (hi - lo) / 2;
    a = shadow_elems[lo];
    b = shadow_elems[hi];
    c = shadow_elems[mid];
    if (a < b)
      piv = (c < a) ? lo : (c > b) ? hi : mid;
    else
      piv = (c > a) ? lo : (c < b) ? hi : mid;
    swap_elems(piv, hi);
    pv = shadow_elems[hi];
    pos = lo;
    for (s = lo; s < hi; s++) begin
      if (shadow_elems[s] < pv) begin
        swap_elems(s, pos);
        pos++;
      end
    end
    swap_elems(hi, pos);
    return pos;
  endfunction

  function automatic logic [31:0] select_rank(int unsigned n, int unsigned k);
    int unsigned lo, hi, p;
    lo = 0;
    hi = n - 1;
    forever begin
      p = partition_window(lo, hi);
      if (p == k)
        return shadow_elems[k];
      if (p < k)
        lo = p + 1;
      else
        hi = p - 1;
    end
  endfunction

  // stores one element, or flags overflow when full; on a closing item yields the expected result
  function automatic bit absorb_element(logic [31:0] v, kss_pkg::rank_t r, logic l,
                                        output pick_t res);
    res = '0;
    if (shadow_count < kss_pkg::MAX_ELEMENTS) begin
      shadow_elems[shadow_count] = v;
      shadow_count++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (!l)
      return 1'b0;
    if (shadow_overflow)
      res.status = kss_pkg::STATUS_OVERFLOW;
    else if (r >= shadow_count)
      res.status = kss_pkg::STATUS_BAD_RANK;
    else begin
      res.status = kss_pkg::STATUS_OK;
      res.value = select_rank(shadow_count, r);
    end
    shadow_count = 0;
    shadow_overflow = 1'b0;
    return 1'b1;
  endfunction

  task automatic drive_item(input logic [31:0] v, input kss_pkg::rank_t r, input logic l,
                            input logic typed, input pick_t want);
    pick_t got;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      element_value <= $urandom;
      last_element <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    element_value <= v;
    wanted_rank <= r;
    last_element <= l;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    if (absorb_element(v, r, l, got))
      expected_picks.push_back(typed ? want : got);
  endtask

  task automatic drain_picks();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_picks.size() != 0)
      @(posedge clk);
  endtask

  task automatic send_random_set(input int unsigned n, input bit bad_rank);
    value_shape_e shape;
    logic [31:0] base, step, v;
    kss_pkg::rank_t r;
    int unsigned i;
    shape = value_shape_e'($urandom_range(SHAPE_EXTREME));
    base = $urandom;
    step = $urandom_range(1 << 20, 1);
    for (i = 0; i < n; i++) begin
      case (shape)
        SHAPE_RANDOM:  v = $urandom;
        SHAPE_NARROW:  v = $urandom_range(7);
        SHAPE_EQUAL:   v = base;
        SHAPE_RISING:  v = base + i * step;
        SHAPE_FALLING: v = base - i * step;
        default: begin
          case ($urandom_range(3))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h8000_0000;
            default: v = $urandom;
          endcase
        end
      endcase
      if (i != n - 1 || n > kss_pkg::MAX_ELEMENTS)
        r = kss_pkg::rank_t'($urandom_range(1023));
      else if (bad_rank && n < kss_pkg::MAX_ELEMENTS)
        r = kss_pkg::rank_t'($urandom_range(1023, n));
      else
        r = kss_pkg::rank_t'($urandom_range(n - 1, 0));
      drive_item(v, r, i == n - 1, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned ph, n, phase_items;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[k])
      drive_item(DIRECTED_ROWS[k].value, DIRECTED_ROWS[k].rank, DIRECTED_ROWS[k].last,
                 DIRECTED_ROWS[k].typed,
                 '{DIRECTED_ROWS[k].want_value, DIRECTED_ROWS[k].want_status});
    drain_picks();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 45; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      // store filled, then one element dropped
      if (ph == 0)
        send_random_set(kss_pkg::MAX_ELEMENTS + 1, 1'b0);
      phase_items = 0;
      while (phase_items < SMALL_SET_ITEMS) begin
        n = ($urandom_range(4) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
        if ($urandom_range(7) == 0)
          drain_picks();
        send_random_set(n, $urandom_range(9) == 0);
        phase_items += n;
      end
      drain_picks();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("kth_smallest_select_tb OK");
    else
      $display("kth_smallest_select_tb NOT OK");
    $finish;
  end

endmodule
